// ===== design/ucb1_child_selector_assert.svh =====
// ---------------------------------------------------------------------------
// ucb1 child selector assertion macros
// shared concurrent assertion shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef UCB1_CHILD_SELECTOR_ASSERT_SVH
`define UCB1_CHILD_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define UCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ucs_pkg.sv =====
// ---------------------------------------------------------------------------
// ucs_pkg
// types and constants of the ucb1 child selector
// ---------------------------------------------------------------------------
package ucs_pkg;

  localparam logic [15:0] WEIGHT_RESET = 16'd5793;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic signed [47:0] SCORE_MIN = 48'sh8000_0000_0000;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_CHK  = 15'b000000000000010,
    S_NORM = 15'b000000000000100,
    S_LG   = 15'b000000000001000,
    S_LGC  = 15'b000000000010000,
    S_LN   = 15'b000000000100000,
    S_LNC  = 15'b000000001000000,
    S_DIVM = 15'b000000010000000,
    S_DIVR = 15'b000000100000000,
    S_SQ   = 15'b000001000000000,
    S_SQC  = 15'b000010000000000,
    S_EXP  = 15'b000100000000000,
    S_EXPC = 15'b001000000000000,
    S_CMP  = 15'b010000000000000,
    S_FIN  = 15'b100000000000000
  } state_t;

endpackage

// ===== design/ucs_stream_if.sv =====
// ---------------------------------------------------------------------------
// ucs stream interfaces
// child statistics channel and selection result channel
// ---------------------------------------------------------------------------
interface ucs_in_if;
  logic               valid;
  logic               ready;
  logic [23:0]        parent_visits;
  logic [23:0]        child_visits;
  logic signed [40:0] child_value_sum;
  logic               last_child;

  modport source (output valid, parent_visits, child_visits, child_value_sum,
                  last_child, input ready);
  modport sink   (input valid, parent_visits, child_visits, child_value_sum,
                  last_child, output ready);
endinterface

interface ucs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_position;
  logic       was_unvisited;

  modport source (output valid, best_position, was_unvisited, input ready);
  modport sink   (input valid, best_position, was_unvisited, output ready);
endinterface

// ===== design/ucs_mul.sv =====
// ---------------------------------------------------------------------------
// ucs_mul
// shared 32 x 32 unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module ucs_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule

// ===== design/ucb1_child_selector.sv =====
// ---------------------------------------------------------------------------
// ucb1_child_selector
// ucb1 child selection over one run of child statistics
// ---------------------------------------------------------------------------
// One child beat is taken at a time and the input stays not ready until it is
// done. A child with visits passes the mean division, the log-over-visits
// division, the 20 square-root rounds on the shared multiplier, and accept,
// check, scoring and finish. The first child of a run with nonzero parent
// visits first passes the normalise steps and the log iterations. A
// zero-visit child, or one after an unvisited child was found, goes from
// check straight to finish. The result beat is issued on the last child and
// waits in an output register; the last child holds the input off only while
// an earlier result beat is still waiting there.
module ucb1_child_selector #(
  parameter int MAX_CHILDREN = 256,
  parameter int VISIT_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  ucs_in_if.sink      in_ch,
  ucs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import ucs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
  localparam int VB_CAP = (VISIT_BITS < 24) ? VISIT_BITS : 24;
  localparam logic [23:0] VIS_LIM = 24'((33'd1 << VB_CAP) - 33'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHILDREN);

  state_t state_r;
  logic [15:0]        weight_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   best_idx_r;
  logic signed [47:0] best_score_r;
  logic               unv_r;
  logic [31:0]        plog_r;

  logic [23:0]        cv_r;
  logic [40:0]        mag_r;
  logic               neg_r, last_r;

  logic [40:0]        num_r;
  logic [23:0]        rem_r;
  logic [5:0]         rnd_r;
  logic [31:0]        y_r;
  logic [4:0]         e_r;
  logic [23:0]        frac_r;
  logic [39:0]        v_r;
  logic [19:0]        root_r;
  logic signed [47:0] mean_r, score_r;

  logic               out_valid_r, out_unv_r;
  logic [7:0]         out_pos_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [23:0] pv_sat, cv_sat;
  logic [40:0] raw_in;
  logic [24:0] trial;
  logic        qbit;
  logic [40:0] num_step;
  logic [23:0] rem_step;
  logic [19:0] trial_root;
  logic [32:0] yy;
  logic [CNT_W+7:0] pos_ext;
  logic        slot_free;
  logic        res_fire;

  assign pv_sat = (in_ch.parent_visits > VIS_LIM) ? VIS_LIM : in_ch.parent_visits;
  assign cv_sat = (in_ch.child_visits > VIS_LIM) ? VIS_LIM : in_ch.child_visits;
  assign raw_in = in_ch.child_value_sum;

  // one restoring division step
  assign trial    = {rem_r, num_r[40]};
  assign qbit     = trial >= {1'b0, cv_r};
  assign rem_step = qbit ? 24'(trial - {1'b0, cv_r}) : trial[23:0];
  assign num_step = {num_r[39:0], qbit};

  assign trial_root = root_r | (20'd1 << rnd_r[4:0]);
  assign yy         = mul_p[63:31];
  assign pos_ext    = {8'b0, best_idx_r};
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign res_fire   = (state_r == S_FIN) && last_r && slot_free;

  always_comb begin
    case (state_r)
      S_LG: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_LN: begin
        mul_a = 32'({e_r, frac_r});
        mul_b = LN2_Q32;
      end
      S_SQ: begin
        mul_a = 32'(trial_root);
        mul_b = 32'(trial_root);
      end
      S_EXP: begin
        mul_a = 32'(weight_r);
        mul_b = 32'(root_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ucs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_we) begin
      weight_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      best_idx_r   <= '0;
      best_score_r <= SCORE_MIN;
      unv_r        <= 1'b0;
      plog_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !res_fire) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cv_r   <= cv_sat;
            neg_r  <= raw_in[40];
            mag_r  <= raw_in[40] ? 41'(-raw_in) : raw_in;
            last_r <= in_ch.last_child;
            y_r    <= {8'b0, pv_sat};
            e_r    <= 5'd31;
            frac_r <= '0;
            if (cnt_r == '0 && pv_sat != '0) begin
              state_r <= S_NORM;
            end else begin
              if (cnt_r == '0) plog_r <= '0;
              state_r <= S_CHK;
            end
          end
        end
        S_NORM: begin
          if (y_r[31]) begin
            rnd_r   <= 6'd23;
            state_r <= S_LG;
          end else begin
            y_r     <= {y_r[30:0], 1'b0};
            e_r     <= e_r - 5'd1;
          end
        end
        S_LG: state_r <= S_LGC;
        S_LGC: begin
          if (yy[32]) begin
            y_r           <= yy[32:1];
            frac_r[rnd_r[4:0]] <= 1'b1;
          end else begin
            y_r <= yy[31:0];
          end
          if (rnd_r == '0) state_r <= S_LN;
          else begin
            rnd_r   <= rnd_r - 6'd1;
            state_r <= S_LG;
          end
        end
        S_LN: state_r <= S_LNC;
        S_LNC: begin
          plog_r  <= mul_p[63:32];
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (cnt_r < CNT_MAX && !unv_r) begin
            if (cv_r == '0) begin
              unv_r      <= 1'b1;
              best_idx_r <= cnt_r;
              state_r    <= S_FIN;
            end else begin
              num_r   <= mag_r;
              rem_r   <= '0;
              rnd_r   <= 6'd40;
              state_r <= S_DIVM;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIVM: begin
          if (rnd_r == '0) begin
            mean_r  <= neg_r ? $signed({7'b0, num_step}) : -$signed({7'b0, num_step});
            num_r   <= {9'b0, plog_r};
            rem_r   <= '0;
            rnd_r   <= 6'd40;
            state_r <= S_DIVR;
          end else begin
            num_r <= num_step;
            rem_r <= rem_step;
            rnd_r <= rnd_r - 6'd1;
          end
        end
        S_DIVR: begin
          if (rnd_r == '0) begin
            v_r     <= {num_step[31:0], 8'b0};
            root_r  <= '0;
            rnd_r   <= 6'd19;
            state_r <= S_SQ;
          end else begin
            num_r <= num_step;
            rem_r <= rem_step;
            rnd_r <= rnd_r - 6'd1;
          end
        end
        S_SQ: state_r <= S_SQC;
        S_SQC: begin
          if (mul_p <= {24'b0, v_r}) root_r <= trial_root;
          if (rnd_r == '0) state_r <= S_EXP;
          else begin
            rnd_r   <= rnd_r - 6'd1;
            state_r <= S_SQ;
          end
        end
        S_EXP: state_r <= S_EXPC;
        S_EXPC: begin
          score_r <= mean_r + $signed({24'b0, mul_p[35:12]});
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (score_r > best_score_r) begin
            best_score_r <= score_r;
            best_idx_r   <= cnt_r;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!last_r) begin
            if (cnt_r < CNT_MAX) cnt_r <= cnt_r + 1'b1;
            state_r <= S_IDLE;
          end else if (slot_free) begin
            // result beat out, run state back to its start
            out_valid_r  <= 1'b1;
            out_pos_r    <= pos_ext[7:0];
            out_unv_r    <= unv_r;
            cnt_r        <= '0;
            best_idx_r   <= '0;
            best_score_r <= SCORE_MIN;
            unv_r        <= 1'b0;
            plog_r       <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_position = out_pos_r;
  assign out_ch.was_unvisited = out_unv_r;

endmodule

// ===== design/ucs_checker.sv =====
// ---------------------------------------------------------------------------
// ucs_checker
// port-level assertions for the ucb1 child selector
// ---------------------------------------------------------------------------
`include "ucb1_child_selector_assert.svh"

module ucs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_best_position,
  input logic       out_was_unvisited
);

  logic [8:0] out_payload;

  assign out_payload = {out_best_position, out_was_unvisited};

  `UCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `UCS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload), "result moved")
  // a taken child beat keeps the input not ready at least through the check and finish states
  `UCS_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready ##1 !in_ready, "child beat too short")
  // a result appears only at the close of a child beat
  `UCS_ASSERT_NOW(a_res_src, $rose(out_valid), $past(!in_ready), "result without child beat")

endmodule

bind ucb1_child_selector ucs_checker u_ucs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_best_position (out_ch.best_position),
  .out_was_unvisited (out_ch.was_unvisited)
);
